// ===== src/emg_envelope_feature_defines.svh =====
// Assertion macros shared by the EMG envelope feature RTL.
`ifndef EMG_ENVELOPE_FEATURE_DEFINES_SVH
`define EMG_ENVELOPE_FEATURE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// ===== src/emgef_pkg.sv =====
// Types, constants and register codes for the EMG envelope feature.
`timescale 1ns / 1ps

package emgef_pkg;

    // Field and register widths
    localparam int SAMPLE_W = 8;
    localparam int DZ_W     = 10;
    localparam int GAIN_W   = 10;
    localparam int RW_W     = 7;
    localparam int ENV_W    = 24;
    localparam int TAPS     = 7;

    // APB
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Matched filter
    localparam int SUM3_W = SAMPLE_W + 2;
    localparam int MF_W   = 18;
    localparam int U_W    = 16;
    localparam logic signed [3:0] FALL_WEIGHT = 4'sd7;

    // Lowpass fixed point
    localparam int STATE_W         = 48;
    localparam int STATE_FRAC_BITS = 32;
    localparam int COEF_FRAC_BITS  = 40;
    localparam int COEF_W          = 42;

    // Coefficients rounded to COEF_FRAC_BITS fraction bits
    localparam logic signed [COEF_W-1:0] COEF_B  = 42'sd1733198;
    localparam logic signed [COEF_W-1:0] COEF_A0 = -42'sd1095610563511;
    localparam logic signed [COEF_W-1:0] COEF_A1 = 42'sd2195115258494;

    // Digit-serial MAC
    localparam int DIG_W = 4;
    localparam int OP_W  = 52;
    localparam int N_DIG = OP_W / DIG_W;
    localparam int CNT_W = $clog2(N_DIG + 1);
    localparam int ACC_W = 48;
    localparam int LOW_W = OP_W - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

    // Output scaling
    localparam int SUM_W  = STATE_W + 2;
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int GPAD_W = ((GAIN_W + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int GDIG_N = GPAD_W / DIG_W;
    localparam int GCNT_W = $clog2(GDIG_N);
    localparam int RND_W  = PROD_W - STATE_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(1) << (STATE_FRAC_BITS - 1);
    localparam logic signed [ENV_W-1:0] ENV_MAX = {1'b0, {(ENV_W-1){1'b1}}};
    localparam logic signed [ENV_W-1:0] ENV_MIN = {1'b1, {(ENV_W-1){1'b0}}};

    // Config register reset values
    localparam logic [DZ_W-1:0]   DZ_RESET   = 10'd30;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd400;
    localparam logic [RW_W-1:0]   RW_RESET   = 7'd7;

    typedef enum logic [1:0] {
        REG_DEAD_ZONE   = 2'd0,
        REG_OUTPUT_GAIN = 2'd1,
        REG_RISE_WEIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        LP_IDLE,
        LP_RUN,
        LP_SAT,
        LP_HOLD
    } t_lp_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_OUT
    } t_sc_state;

    typedef struct packed {
        logic           start;
        logic [U_W-1:0] u;
    } t_lp_start;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } t_sum_req;

endpackage

// ===== src/emg_envelope_feature.sv =====
// EMG envelope feature: config registers, matched filter, lowpass and output scaling.
// An accepted request passes the matched filter, the lowpass MAC, saturate and handoff
// and the output gain before o_out_valid. A new request is taken only once the lowpass
// is idle again, after its 13-digit serial MAC, saturate state and handoff to the scaler.
// Reset (synchronous, active low) clears sample history and filter state, loads the
// register defaults and drops o_out_valid.
`timescale 1ns / 1ps

module emg_envelope_feature
    import emgef_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [ENV_W-1:0]    o_envelope,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    logic [DZ_W-1:0]   r_dead_zone;
    logic [GAIN_W-1:0] r_output_gain;
    logic [RW_W-1:0]   r_rise_weight;
    logic              w_cfg_wr;
    t_reg_idx          w_reg;
    logic              w_accept;
    logic              w_lp_ready;
    logic              w_sc_ready;
    logic [U_W-1:0]    w_u;
    t_lp_start         w_start;
    t_sum_req          w_sum;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone   <= DZ_RESET;
            r_output_gain <= GAIN_RESET;
            r_rise_weight <= RW_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_DEAD_ZONE:   r_dead_zone   <= pwdata[DZ_W-1:0];
                REG_OUTPUT_GAIN: r_output_gain <= pwdata[GAIN_W-1:0];
                REG_RISE_WEIGHT: r_rise_weight <= pwdata[RW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_DEAD_ZONE:   prdata = DATA_W'(r_dead_zone);
            REG_OUTPUT_GAIN: prdata = DATA_W'(r_output_gain);
            REG_RISE_WEIGHT: prdata = DATA_W'(r_rise_weight);
            default:         prdata = '0;
        endcase
    end

    // a new request enters whenever the lowpass is idle
    assign o_in_stall    = !w_lp_ready;
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_start.start = w_accept;
    assign w_start.u     = w_u;

    emgef_match u_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_shift       (w_accept),
        .i_sample      (i_sample),
        .i_dead_zone   (r_dead_zone),
        .i_rise_weight (r_rise_weight),
        .o_u           (w_u)
    );

    emgef_lowpass u_lowpass (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .o_ready    (w_lp_ready),
        .o_sum      (w_sum),
        .i_sum_take (w_sc_ready)
    );

    emgef_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_output_gain),
        .i_sum       (w_sum),
        .o_ready     (w_sc_ready),
        .o_out_valid (o_out_valid),
        .o_envelope  (o_envelope),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== src/emgef_match.sv =====
// Sample history and matched filter with dead zone.
`timescale 1ns / 1ps

module emgef_match
    import emgef_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [DZ_W-1:0]            i_dead_zone,
    input  logic [RW_W-1:0]            i_rise_weight,
    output logic [U_W-1:0]             o_u
);

    logic signed [SAMPLE_W-1:0] r_hist [TAPS];
    logic signed [SUM3_W-1:0]   w_new;
    logic signed [SUM3_W-1:0]   w_old;
    logic signed [MF_W-1:0]     w_rise;
    logic signed [MF_W-1:0]     w_fall;
    logic signed [MF_W-1:0]     w_m;
    logic signed [MF_W-1:0]     w_ex;

    // index 0 holds the newest sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) r_hist[i] <= '0;
        end else if (i_shift) begin
            r_hist[0] <= i_sample;
            for (int i = 1; i < TAPS; i++) r_hist[i] <= r_hist[i-1];
        end
    end

    // uses the history before the new sample enters
    assign w_new  = SUM3_W'(r_hist[0]) + SUM3_W'(r_hist[1]) + SUM3_W'(r_hist[2]);
    assign w_old  = SUM3_W'(r_hist[TAPS-3]) + SUM3_W'(r_hist[TAPS-2])
                  + SUM3_W'(r_hist[TAPS-1]);
    assign w_rise = MF_W'(w_old) * $signed({{(MF_W-RW_W){1'b0}}, i_rise_weight});
    assign w_fall = MF_W'(w_new) * MF_W'(FALL_WEIGHT);
    assign w_m    = w_rise - w_fall;
    assign w_ex   = w_m - $signed({{(MF_W-DZ_W){1'b0}}, i_dead_zone});
    assign o_u    = (w_ex > MF_W'(0)) ? w_ex[U_W-1:0] : '0;

endmodule

// ===== src/emgef_lowpass.sv =====
// Digit-serial second-order lowpass: MAC over 4-bit digits, saturate, state update.
`timescale 1ns / 1ps
`include "emg_envelope_feature_defines.svh"

module emgef_lowpass
    import emgef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lp_start i_start,
    output logic      o_ready,
    output t_sum_req  o_sum,
    input  logic      i_sum_take
);

    t_lp_state                   r_state, n_state;
    logic [CNT_W-1:0]            r_cnt;
    logic [OP_W-1:0]             r_op0, r_op1, r_opu;
    logic signed [ACC_W-1:0]     r_acc;
    logic [LOW_W-1:0]            r_low;
    logic signed [STATE_W-1:0]   r_v0, r_v1;
    logic signed [SUM_W-1:0]     r_sum;
    logic                        w_last;
    logic                        w_fit;
    logic signed [DIG_W:0]       w_d0, w_d1, w_du;
    logic signed [COEF_W+DIG_W:0] w_p0, w_p1, w_pu;
    logic signed [ACC_W-1:0]     w_nsum;
    logic signed [STATE_W-1:0]   w_v2;
    logic signed [SUM_W-1:0]     w_sum;

    // top digit of a multiplicand carries the sign
    function automatic logic signed [DIG_W:0] f_digit(input logic [DIG_W-1:0] d,
                                                      input logic top);
        return top ? $signed({d[DIG_W-1], d}) : $signed({1'b0, d});
    endfunction

    assign w_last = (r_cnt == CNT_W'(N_DIG - 1));
    assign w_d0   = f_digit(r_op0[DIG_W-1:0], w_last);
    assign w_d1   = f_digit(r_op1[DIG_W-1:0], w_last);
    assign w_du   = f_digit(r_opu[DIG_W-1:0], w_last);
    assign w_p0   = COEF_A0 * w_d0;
    assign w_p1   = COEF_A1 * w_d1;
    assign w_pu   = COEF_B * w_du;
    assign w_nsum = r_acc + ACC_W'(w_p0) + ACC_W'(w_p1) + ACC_W'(w_pu);

    // result = acc * 2^LOW_W + low digits; fits in 48 bits when the top bits agree
    assign w_fit = (&r_acc[ACC_W-1:STATE_W-LOW_W-1]) || (~|r_acc[ACC_W-1:STATE_W-LOW_W-1]);
    assign w_v2  = w_fit ? $signed({r_acc[STATE_W-LOW_W-1:0], r_low})
                         : (r_acc[ACC_W-1] ? STATE_MIN : STATE_MAX);
    assign w_sum = SUM_W'(r_v0) + (SUM_W'(r_v1) <<< 1) + SUM_W'(w_v2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LP_IDLE: if (i_start.start) n_state = LP_RUN;
            LP_RUN:  if (w_last) n_state = LP_SAT;
            LP_SAT:  n_state = LP_HOLD;
            LP_HOLD: if (i_sum_take) n_state = LP_IDLE;
            default: n_state = LP_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == LP_IDLE);
        o_sum.valid = (r_state == LP_HOLD);
        o_sum.sum   = r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LP_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == LP_RUN) r_cnt <= r_cnt + CNT_W'(1);
            else r_cnt <= '0;
        end
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= '0;
            r_v1 <= '0;
        end else if (r_state == LP_SAT) begin
            r_v0 <= r_v1;
            r_v1 <= w_v2;
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (r_state == LP_IDLE && i_start.start) begin
            r_op0 <= OP_W'(r_v0);
            r_op1 <= OP_W'(r_v1);
            r_opu <= OP_W'({i_start.u, {STATE_FRAC_BITS{1'b0}}});
            r_acc <= ACC_RND;
            r_low <= '0;
        end else if (r_state == LP_RUN) begin
            r_op0 <= r_op0 >> DIG_W;
            r_op1 <= r_op1 >> DIG_W;
            r_opu <= r_opu >> DIG_W;
            r_acc <= w_nsum >>> DIG_W;
            r_low <= {w_nsum[DIG_W-1:0], r_low[LOW_W-1:DIG_W]};
        end
        if (r_state == LP_SAT) r_sum <= w_sum;
    end

    `ASSERT_NEVER(a_start_busy, i_start.start && (r_state != LP_IDLE))
    `ASSERT_CLK(a_state_shift, (r_state == LP_SAT) |=> (r_v0 == $past(r_v1)))
    `ASSERT_CLK(a_hold_stable, (r_state == LP_HOLD) && !i_sum_take |=> (r_state == LP_HOLD) && $stable(r_sum))

endmodule

// ===== src/emgef_scale.sv =====
// Digit-serial output gain, rounding, saturation and output register.
`timescale 1ns / 1ps
`include "emg_envelope_feature_defines.svh"

module emgef_scale
    import emgef_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [GAIN_W-1:0]       i_gain,
    input  t_sum_req                i_sum,
    output logic                    o_ready,
    output logic                    o_out_valid,
    output logic signed [ENV_W-1:0] o_envelope,
    input  logic                    i_out_stall
);

    t_sc_state                     r_state, n_state;
    logic [GCNT_W-1:0]             r_cnt;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [PROD_W-1:0]      r_p;
    logic [GPAD_W-1:0]             r_g;
    logic                          r_out_valid;
    logic signed [ENV_W-1:0]       r_env;
    logic [DIG_W-1:0]              w_gd;
    logic signed [SUM_W+DIG_W:0]   w_part;
    logic signed [PROD_W-1:0]      w_pnext;
    logic signed [PROD_W-1:0]      w_rnd;
    logic signed [RND_W-1:0]       w_r;
    logic signed [ENV_W-1:0]       w_env;
    logic                          w_last;
    logic                          w_free;

    // gain digits taken MSB first
    assign w_gd    = r_g[GPAD_W-1 -: DIG_W];
    assign w_part  = r_sum * $signed({1'b0, w_gd});
    assign w_pnext = (r_p <<< DIG_W) + PROD_W'(w_part);
    assign w_last  = (r_cnt == GCNT_W'(GDIG_N - 1));

    assign w_rnd = r_p + PROD_RND;
    assign w_r   = $signed(w_rnd[PROD_W-1:STATE_FRAC_BITS]);
    assign w_env = ((&w_r[RND_W-1:ENV_W-1]) || (~|w_r[RND_W-1:ENV_W-1]))
                   ? w_r[ENV_W-1:0]
                   : (w_r[RND_W-1] ? ENV_MIN : ENV_MAX);

    // output register free when empty or being taken this cycle
    assign w_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SC_IDLE: if (i_sum.valid) n_state = SC_MUL;
            SC_MUL:  if (w_last) n_state = SC_OUT;
            SC_OUT:  if (w_free) n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == SC_IDLE);
        o_out_valid = r_out_valid;
        o_envelope  = r_env;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SC_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == SC_MUL) r_cnt <= r_cnt + GCNT_W'(1);
            else r_cnt <= '0;
            if (r_state == SC_OUT && w_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SC_IDLE && i_sum.valid) begin
            r_sum <= i_sum.sum;
            r_p   <= '0;
            r_g   <= GPAD_W'(i_gain);
        end else if (r_state == SC_MUL) begin
            r_p <= w_pnext;
            r_g <= r_g << DIG_W;
        end
        if (r_state == SC_OUT && w_free) r_env <= w_env;
    end

    `ASSERT_CLK(a_out_written, (r_state == SC_OUT) && w_free |=> r_out_valid)

endmodule
